### design/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

    // Code points and unit values
    localparam logic [15:0] UNIT_REPL      = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] CP_MIN_2       = 21'h000080;
    localparam logic [20:0] CP_MIN_3       = 21'h000800;
    localparam logic [20:0] CP_MIN_4       = 21'h010000;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;

    // Byte class boundaries
    localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
    localparam logic [7:0] BYTE_LEAD2_LO = 8'hC0;
    localparam logic [7:0] BYTE_LEAD3_LO = 8'hE0;
    localparam logic [7:0] BYTE_LEAD4_LO = 8'hF0;
    localparam logic [7:0] BYTE_BAD_LO   = 8'hF8;

    // Sequence lengths held in the decoder state
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // Job queue between decoder and unit sequencer
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_of_run;
    } unit_item_t;

    // One job: replacement units first, then up to two valid units
    typedef struct packed {
        logic [2:0]  repl_count;
        logic [1:0]  tail_count;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

endpackage

### design/u8u16_front.sv
`timescale 1ns / 1ps

module u8u16_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  u8u16_pkg::byte_item_t byte_data,
    input  logic                 q_full,
    output u8u16_pkg::q_wr_t     q_wr
);
    import u8u16_pkg::*;

    logic [2:0]  seq_len_reg, seq_len_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [14:0] gathered_bits_reg, gathered_bits_next;

    logic [7:0]  b;
    logic        eot;
    logic        accept;
    logic        is_cont;
    logic        fresh;
    logic        seq_ok;
    logic [20:0] cp;
    logic [20:0] cp_off;
    logic [2:0]  repl;
    logic [1:0]  tail;
    logic [15:0] u0;
    logic [15:0] u1;

    assign b          = byte_data.in_byte;
    assign eot        = byte_data.end_of_text;
    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;
    assign is_cont    = (b[7:6] == 2'b10);
    assign cp         = {gathered_bits_reg, b[5:0]};
    assign cp_off     = cp - CP_MIN_4;

    always_comb
    begin
        unique case (seq_len_reg)
            SEQ_LEN2: seq_ok = (cp >= CP_MIN_2);
            SEQ_LEN3: seq_ok = (cp >= CP_MIN_3) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
            default:  seq_ok = (cp >= CP_MIN_4) && (cp <= CP_MAX);
        endcase
    end

    always_comb
    begin
        seq_len_next       = seq_len_reg;
        pend_cnt_next      = pend_cnt_reg;
        gathered_bits_next = gathered_bits_reg;
        repl               = 3'd0;
        tail               = 2'd0;
        u0                 = {8'h00, b};
        u1                 = 16'h0000;
        fresh              = 1'b0;

        if (seq_len_reg == SEQ_NONE)
        begin
            fresh = 1'b1;
        end
        else if (is_cont)
        begin
            if (({1'b0, pend_cnt_reg} + 3'd2) >= seq_len_reg)
            begin
                // sequence complete: emit it or replace every byte
                seq_len_next       = SEQ_NONE;
                pend_cnt_next      = 2'd0;
                gathered_bits_next = '0;
                if (!seq_ok)
                begin
                    repl = seq_len_reg;
                end
                else if (cp >= CP_MIN_4)
                begin
                    tail = 2'd2;
                    u0   = HIGH_SURR_BASE + {6'd0, cp_off[19:10]};
                    u1   = LOW_SURR_BASE + {6'd0, cp_off[9:0]};
                end
                else
                begin
                    tail = 2'd1;
                    u0   = cp[15:0];
                end
            end
            else if (eot)
            begin
                seq_len_next       = SEQ_NONE;
                pend_cnt_next      = 2'd0;
                gathered_bits_next = '0;
                repl               = {1'b0, pend_cnt_reg} + 3'd2;
            end
            else
            begin
                pend_cnt_next      = pend_cnt_reg + 2'd1;
                gathered_bits_next = cp[14:0];
            end
        end
        else
        begin
            // interrupted: replace collected bytes, then decode this one fresh
            seq_len_next       = SEQ_NONE;
            pend_cnt_next      = 2'd0;
            gathered_bits_next = '0;
            repl               = {1'b0, pend_cnt_reg} + 3'd1;
            fresh              = 1'b1;
        end

        if (fresh)
        begin
            priority if (b < BYTE_CONT_LO)
            begin
                tail = 2'd1;
                u0   = {8'h00, b};
            end
            else if ((b < BYTE_LEAD2_LO) || (b >= BYTE_BAD_LO) || eot)
            begin
                repl = repl + 3'd1;
            end
            else if (b < BYTE_LEAD3_LO)
            begin
                seq_len_next       = SEQ_LEN2;
                pend_cnt_next      = 2'd0;
                gathered_bits_next = {10'd0, b[4:0]};
            end
            else if (b < BYTE_LEAD4_LO)
            begin
                seq_len_next       = SEQ_LEN3;
                pend_cnt_next      = 2'd0;
                gathered_bits_next = {11'd0, b[3:0]};
            end
            else
            begin
                seq_len_next       = SEQ_LEN4;
                pend_cnt_next      = 2'd0;
                gathered_bits_next = {12'd0, b[2:0]};
            end
        end
    end

    assign q_wr.push           = accept && ((repl != 3'd0) || (tail != 2'd0));
    assign q_wr.job.repl_count = repl;
    assign q_wr.job.tail_count = tail;
    assign q_wr.job.unit0      = u0;
    assign q_wr.job.unit1      = u1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg       <= SEQ_NONE;
            pend_cnt_reg      <= 2'd0;
            gathered_bits_reg <= '0;
        end
        else if (accept)
        begin
            seq_len_reg       <= seq_len_next;
            pend_cnt_reg      <= pend_cnt_next;
            gathered_bits_reg <= gathered_bits_next;
        end
    end

endmodule

### design/u8u16_queue.sv
`timescale 1ns / 1ps

module u8u16_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  u8u16_pkg::q_wr_t   q_wr,
    output logic               q_full,
    input  logic               q_pop,
    output u8u16_pkg::q_head_t q_head
);
    import u8u16_pkg::*;

    job_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_head.valid = (count_reg != '0);
    assign q_head.job   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (q_wr.push && !q_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!q_wr.push && q_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_wr.push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            entries_reg[wr_ptr_reg] <= q_wr.job;
    end

endmodule

### design/u8u16_back.sv
`timescale 1ns / 1ps

module u8u16_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8u16_pkg::q_head_t    q_head,
    output logic                  q_pop,
    output logic                  unit_valid,
    input  logic                  unit_ready,
    output u8u16_pkg::unit_item_t unit_data
);
    import u8u16_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        unit_valid_reg;
    unit_item_t  unit_data_reg, unit_data_next;

    logic        emit;
    logic [2:0]  idx_ext;
    logic [2:0]  total;
    logic [2:0]  tail_pos;
    logic        last;

    assign emit     = q_head.valid && (!unit_valid_reg || unit_ready);
    assign idx_ext  = {1'b0, idx_reg};
    assign total    = q_head.job.repl_count + {1'b0, q_head.job.tail_count};
    assign last     = (idx_ext == (total - 3'd1));
    assign tail_pos = idx_ext - q_head.job.repl_count;
    assign q_pop    = emit && last;
    assign idx_next = last ? 2'd0 : (idx_reg + 2'd1);

    always_comb
    begin
        unit_data_next.last_of_run = last;
        if (idx_ext < q_head.job.repl_count)
        begin
            unit_data_next.code_unit      = UNIT_REPL;
            unit_data_next.is_replacement = 1'b1;
        end
        else
        begin
            unit_data_next.code_unit      = tail_pos[0] ? q_head.job.unit1 : q_head.job.unit0;
            unit_data_next.is_replacement = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= 2'd0;
            unit_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                idx_reg        <= idx_next;
                unit_valid_reg <= 1'b1;
            end
            else if (unit_ready)
            begin
                unit_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            unit_data_reg <= unit_data_next;
    end

    assign unit_valid = unit_valid_reg;
    assign unit_data  = unit_data_reg;

endmodule

### design/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// byte      in         byte_valid/byte_ready   byte_data: in_byte, end_of_text
// unit      out        unit_valid/unit_ready   unit_data: code_unit, is_replacement,
//                                                         last_of_run
//
// One byte is taken per cycle while the job queue has room; one code unit
// leaves per cycle from the output register while unit_ready is high, so
// the unit port sets the rate. A byte that yields n units (n up to four)
// occupies the output for n transfers. The first unit of a byte passes
// through the job queue and then the output register before it is presented.
// Reset clears the decoder state, queue pointers and output valid.
// Stalls on the unit side fill the four-entry queue and then drop byte_ready.

module utf8_to_utf16_transcoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  u8u16_pkg::byte_item_t byte_data,
    output logic                  unit_valid,
    input  logic                  unit_ready,
    output u8u16_pkg::unit_item_t unit_data
);
    import u8u16_pkg::*;

    q_wr_t   q_wr;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;

    // Decode each byte; a byte that yields units becomes a job: replacement count plus valid units
    u8u16_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_wr       (q_wr)
    );

    // Hold jobs so the decoder keeps going while replacement bursts drain
    u8u16_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    // Step through each job one unit per transfer
    u8u16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data)
    );

endmodule

### design/u8u16_checker.sv
`timescale 1ns / 1ps

module u8u16_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  unit_valid,
    input logic                  unit_ready,
    input u8u16_pkg::unit_item_t unit_data
);
    import u8u16_pkg::*;

    // Output holds while stalled
    a_unit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_ready |=> unit_valid && $stable(unit_data))
        else $error("unit output changed while stalled");

    // Replacement flag only ever marks U+FFFD
    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_data.is_replacement |-> unit_data.code_unit == UNIT_REPL)
        else $error("replacement flag on a unit other than U+FFFD");

    // A high surrogate is always followed by its low half from the same byte
    a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && (unit_data.code_unit[15:10] == 6'b110110) |-> !unit_data.last_of_run)
        else $error("high surrogate closes a run");

    // A transferred high surrogate is followed by a low surrogate
    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_ready && (unit_data.code_unit[15:10] == 6'b110110)
        |=> !unit_valid || (unit_data.code_unit[15:10] == 6'b110111))
        else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import u8u16_pkg::*;

    // Receiver behaviour, picked at random and changed at random intervals
    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_SPARSE,  // ready a quarter of the time, at random
        RX_BEAT     // fixed rhythm: ready two fifths of the time
    } rx_mode_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_item_t byte_data  = '0;
    logic       unit_valid;
    logic       unit_ready = 1'b0;
    unit_item_t unit_data;

    // Bytes still to be offered, and UTF-16 units owed by the decoder
    byte_item_t bytes_todo[$];
    unit_item_t units_due[$];
    unit_item_t run_units[$];

    // Decoder state as the predictor tracks it
    logic [1:0]  seq_seen = '0;    // continuation bytes gathered so far
    logic [2:0]  seq_len  = SEQ_NONE;
    logic [20:0] seq_bits = '0;

    int       errors      = 0;
    int       burst_left  = 0;
    int       gap_left    = 0;
    int       stall_timer = 0;
    int       stall_tick  = 0;
    rx_mode_t stall_mode  = RX_OPEN;

    utf8_to_utf16_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_data  (unit_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Count a mismatch and print one line for it
    task automatic flag_error(input string what);
    begin
        errors++;
        $display("ERROR at %0t ns: %s", $time, what);
    end
    endtask

    // ------------------------------------------------------------------
    // Predictor: what the decoder should give for each byte transfer
    // ------------------------------------------------------------------

    // Append one unit to the run of the current byte; a run never exceeds four
    task automatic add_unit(input logic [15:0] code, input logic repl);
        unit_item_t u;
    begin
        if (run_units.size() < 4)
        begin
            u.code_unit      = code;
            u.is_replacement = repl;
            u.last_of_run    = 1'b0;
            run_units.push_back(u);
        end
    end
    endtask

    task automatic add_replacements(input int count);
    begin
        for (int i = 0; i < count; i++)
            add_unit(UNIT_REPL, 1'b1);
    end
    endtask

    // Emit a code point as one unit, or split a supplementary one into a surrogate pair
    task automatic add_code_point(input logic [20:0] cp);
        logic [20:0] offset;
    begin
        if (cp >= CP_MIN_4)
        begin
            offset = cp - CP_MIN_4;
            add_unit(HIGH_SURR_BASE + {6'd0, offset[19:10]}, 1'b0);
            add_unit(LOW_SURR_BASE + {6'd0, offset[9:0]}, 1'b0);
        end
        else
            add_unit(cp[15:0], 1'b0);
    end
    endtask

    function automatic logic sequence_valid(input logic [2:0] len, input logic [20:0] cp);
    begin
        if (len == SEQ_LEN2)
            return cp >= CP_MIN_2;
        if (len == SEQ_LEN3)
            return cp >= CP_MIN_3 && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI);
        return cp >= CP_MIN_4 && cp <= CP_MAX;
    end
    endfunction

    // Decode a byte with no sequence pending
    task automatic open_or_emit(input logic [7:0] b, input logic eot);
        logic [2:0]  len;
        logic [20:0] bits;
    begin
        if (b < BYTE_CONT_LO)
            add_unit({8'd0, b}, 1'b0);
        else if (b < BYTE_LEAD2_LO || b >= BYTE_BAD_LO)
            add_unit(UNIT_REPL, 1'b1);
        else
        begin
            if (b < BYTE_LEAD3_LO)
            begin
                len  = SEQ_LEN2;
                bits = {16'd0, b[4:0]};
            end
            else if (b < BYTE_LEAD4_LO)
            begin
                len  = SEQ_LEN3;
                bits = {17'd0, b[3:0]};
            end
            else
            begin
                len  = SEQ_LEN4;
                bits = {18'd0, b[2:0]};
            end
            // A lead byte that ends the text can never be completed
            if (eot)
                add_unit(UNIT_REPL, 1'b1);
            else
            begin
                seq_len  = len;
                seq_seen = '0;
                seq_bits = bits;
            end
        end
    end
    endtask

    task automatic decode_byte(input byte_item_t item);
        logic [7:0]  b;
        logic [20:0] cp;
        int          seen;
        int          collected;
    begin
        b = item.in_byte;
        run_units.delete();
        if (seq_len == SEQ_NONE)
            open_or_emit(b, item.end_of_text);
        else if (b[7:6] == 2'b10)
        begin
            seen = int'(seq_seen) + 1;
            cp   = {seq_bits[14:0], b[5:0]};
            if (seen + 1 >= int'(seq_len))
            begin
                // Sequence complete: check the form, then emit or replace per byte
                collected = int'(seq_len);
                seq_len   = SEQ_NONE;
                if (sequence_valid(3'(collected), cp))
                    add_code_point(cp);
                else
                    add_replacements(collected);
                seq_seen = '0;
                seq_bits = '0;
            end
            else if (item.end_of_text)
            begin
                // Truncated at end of text: one replacement per byte gathered
                seq_len  = SEQ_NONE;
                seq_seen = '0;
                seq_bits = '0;
                add_replacements(seen + 1);
            end
            else
            begin
                seq_seen = 2'(seen);
                seq_bits = cp;
            end
        end
        else
        begin
            // Interrupted: replace what was gathered, then take the byte afresh
            collected = int'(seq_seen) + 1;
            seq_len   = SEQ_NONE;
            seq_seen  = '0;
            seq_bits  = '0;
            add_replacements(collected);
            open_or_emit(b, item.end_of_text);
        end
        if (run_units.size() > 0)
            run_units[run_units.size() - 1].last_of_run = 1'b1;
        foreach (run_units[i])
            units_due.push_back(run_units[i]);
    end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b, input logic eot);
        byte_item_t item;
    begin
        item.in_byte     = b;
        item.end_of_text = eot;
        bytes_todo.push_back(item);
    end
    endtask

    // Encode cp in len bytes (overlong if cp is small), keep the first nbytes,
    // and flag end of text on the last byte kept if asked
    task automatic queue_sequence(input logic [20:0] cp, input logic [2:0] len,
                                  input int nbytes, input logic eot_last);
        logic [7:0]  b;
        logic [20:0] shifted;
    begin
        for (int k = 0; k < nbytes; k++)
        begin
            if (k == 0)
            begin
                if (len == SEQ_LEN2)
                    b = BYTE_LEAD2_LO | {3'd0, cp[10:6]};
                else if (len == SEQ_LEN3)
                    b = BYTE_LEAD3_LO | {4'd0, cp[15:12]};
                else
                    b = BYTE_LEAD4_LO | {5'd0, cp[20:18]};
            end
            else
            begin
                shifted = cp >> (6 * (int'(len) - 1 - k));
                b       = BYTE_CONT_LO | {2'd0, shifted[5:0]};
            end
            queue_byte(b, eot_last && (k == nbytes - 1));
        end
    end
    endtask

    // A random byte that cannot continue a pending sequence
    function automatic logic [7:0] non_continuation();
        logic [7:0] b;
    begin
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10)
            b[6] = 1'b1;
        return b;
    end
    endfunction

    task automatic queue_random_traffic(input int target);
        int          pick;
        int          len_pick;
        logic [2:0]  len;
        logic [20:0] cp;
        logic        eot;
    begin
        while (bytes_todo.size() < target)
        begin
            pick     = $urandom_range(0, 99);
            eot      = ($urandom_range(0, 11) == 0);
            len_pick = $urandom_range(2, 4);
            len      = (len_pick == 2) ? SEQ_LEN2 : (len_pick == 3) ? SEQ_LEN3 : SEQ_LEN4;
            if (pick < 22)
                queue_byte(8'($urandom_range(0, 127)), eot);
            else if (pick < 40)
                queue_sequence(21'($urandom_range(32'h80, 32'h7FF)), SEQ_LEN2, 2, eot);
            else if (pick < 57)
            begin
                cp = 21'($urandom_range(32'h800, 32'hFFFF));
                // Move surrogate picks up into the range F800-FFFF
                if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                    cp = cp ^ 21'h002000;
                queue_sequence(cp, SEQ_LEN3, 3, eot);
            end
            else if (pick < 70)
                queue_sequence(21'($urandom_range(32'h10000, 32'h10FFFF)), SEQ_LEN4, 4, eot);
            else if (pick < 75)
            begin
                // Overlong: a value that fits a shorter form
                if (len == SEQ_LEN2)
                    cp = 21'($urandom_range(0, 32'h7F));
                else if (len == SEQ_LEN3)
                    cp = 21'($urandom_range(0, 32'h7FF));
                else
                    cp = 21'($urandom_range(0, 32'hFFFF));
                queue_sequence(cp, len, int'(len), eot);
            end
            else if (pick < 79)
                queue_sequence(21'($urandom_range(32'hD800, 32'hDFFF)), SEQ_LEN3, 3, eot);
            else if (pick < 83)
                queue_sequence(21'($urandom_range(32'h110000, 32'h1FFFFF)), SEQ_LEN4, 4, eot);
            else if (pick < 91)
            begin
                // Short sequence: end the text there, or break in with another byte
                cp = 21'($urandom_range(32'h80, 32'h10FFFF));
                if ($urandom_range(0, 1) == 0)
                    queue_sequence(cp, len, $urandom_range(1, int'(len) - 1), 1'b1);
                else
                begin
                    queue_sequence(cp, len, $urandom_range(1, int'(len) - 1), 1'b0);
                    queue_byte(non_continuation(), eot);
                end
            end
            else
                queue_byte(8'($urandom_range(0, 255)), eot);
        end
    end
    endtask

    // ------------------------------------------------------------------
    // Byte driver: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data  <= '0;
            seq_len    = SEQ_NONE;
            seq_seen   = '0;
            seq_bits   = '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // A transfer has happened: work out the units it owes
            if (byte_valid && byte_ready)
                decode_byte(byte_data);
            // Hold the offered byte until it is taken; otherwise advance
            if (!byte_valid || byte_ready)
            begin
                if (gap_left > 0 || bytes_todo.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    byte_valid <= 1'b0;
                end
                else
                begin
                    byte_data  <= bytes_todo.pop_front();
                    byte_valid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    // Some bursts run straight into the next one
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Unit receiver: stall pattern switches between several behaviours
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_ready <= 1'b0;
        else
        begin
            if (stall_timer == 0)
            begin
                stall_mode  = rx_mode_t'($urandom_range(0, 3));
                stall_timer = $urandom_range(20, 120);
            end
            else
                stall_timer--;
            stall_tick++;
            case (stall_mode)
                RX_OPEN:   unit_ready <= 1'b1;
                RX_COIN:   unit_ready <= ($urandom_range(0, 1) == 0);
                RX_SPARSE: unit_ready <= ($urandom_range(0, 3) == 0);
                default:   unit_ready <= ((stall_tick % 5) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Unit monitor: compare each transfer with the oldest owed unit
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        unit_item_t want;
        if (rst_n && unit_valid && unit_ready)
        begin
            if (units_due.size() == 0)
                flag_error($sformatf("unit %h arrived with nothing owed", unit_data.code_unit));
            else
            begin
                want = units_due.pop_front();
                if (unit_data.code_unit !== want.code_unit)
                    flag_error($sformatf("code_unit %h, expected %h",
                                         unit_data.code_unit, want.code_unit));
                if (unit_data.is_replacement !== want.is_replacement)
                    flag_error($sformatf("is_replacement %b on unit %h, expected %b",
                                         unit_data.is_replacement, want.code_unit,
                                         want.is_replacement));
                if (unit_data.last_of_run !== want.last_of_run)
                    flag_error($sformatf("last_of_run %b on unit %h, expected %b",
                                         unit_data.last_of_run, want.code_unit,
                                         want.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the byte stream, release reset, drain, judge
    // ------------------------------------------------------------------
    initial
    begin
        // Directed part: field extremes and each error case once
        queue_byte(8'h00, 1'b0);                                   // lowest ASCII
        queue_byte(BYTE_CONT_LO, 1'b0);                            // stray continuation
        queue_byte(8'hFF, 1'b0);                                   // impossible lead
        queue_sequence(21'h0000E9, SEQ_LEN2, 2, 1'b0);             // valid two-byte
        queue_sequence(21'h000000, SEQ_LEN2, 2, 1'b0);             // overlong
        queue_sequence({5'd0, UNIT_REPL}, SEQ_LEN3, 3, 1'b0);      // genuine U+FFFD
        queue_sequence(CP_SURR_LO, SEQ_LEN3, 3, 1'b0);             // encoded surrogate
        queue_sequence(CP_MAX, SEQ_LEN4, 4, 1'b0);                 // highest code point
        queue_sequence(CP_MAX + 21'd1, SEQ_LEN4, 4, 1'b0);         // above range
        queue_sequence(21'h01F600, SEQ_LEN4, 3, 1'b0);             // broken in by ASCII:
        queue_byte(8'h41, 1'b0);                                   // four units at once
        queue_sequence(21'h0000E9, SEQ_LEN2, 1, 1'b1);             // text ends on a lead
        queue_sequence(21'h01F600, SEQ_LEN4, 2, 1'b1);             // text ends mid-sequence
        queue_byte(8'h7F, 1'b1);                                   // highest ASCII, end
        // Random part: mostly well-formed text, some noise and breakage
        queue_random_traffic(bytes_todo.size() + 380);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be taken and every owed unit to arrive
        while (bytes_todo.size() != 0 || byte_valid || units_due.size() != 0)
            @(posedge clk);
        // Allow any stray late units to show themselves
        repeat (20) @(posedge clk);

        if (errors == 0 && units_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/u8u16_pkg.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/utf8_to_utf16_transcoder.sv
design/u8u16_checker.sv
bench/tb_top.sv
